FILE: hdl/sifr_pkg.sv
package sifr_pkg;

  localparam int unsigned RAW_CAPACITY_DEF = 512;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_OF_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_OF_ESC   = 8'h5D;
  localparam logic [7:0] CTRL_SEQ0    = 8'h00;
  localparam logic [7:0] CTRL_SEQ1    = 8'h40;
  localparam logic [7:0] RR_SEQ0      = 8'h05;
  localparam logic [7:0] RR_SEQ1      = 8'h85;
  localparam logic [7:0] REJ_SEQ0     = 8'h01;
  localparam logic [7:0] REJ_SEQ1     = 8'h81;
  localparam logic [7:0] NO_REPLY     = 8'h00;
  localparam logic [7:0] STATION_RST  = 8'h03;
  localparam logic [8:0] LENGTH_MAX   = 9'd511;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    PH_FLAG    = 5'b00001,
    PH_ADDR    = 5'b00010,
    PH_CTRL    = 5'b00100,
    PH_HCHECK  = 5'b01000,
    PH_BODY    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [7:0] reply_control;
    logic [8:0] frame_length;
  } res_t;

endpackage

FILE: hdl/sifr_step.sv
module sifr_step #(
  parameter int unsigned RawCapacity = sifr_pkg::RAW_CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          station_address,
  output sifr_pkg::res_t      res
);
  import sifr_pkg::*;

  localparam int CW = $clog2(RawCapacity + 1);
  localparam int LW = (CW > 9) ? CW : 9;
  localparam logic [CW-1:0] CAP = CW'(RawCapacity);

  phase_t        phase, phase_next;
  logic          seq_bit, seq_bit_next;
  logic          escape_pending, escape_pending_next;
  logic          bad_escape, bad_escape_next;
  logic          held_valid, held_valid_next;
  logic [7:0]    held_byte, held_byte_next;
  logic [7:0]    running_xor, running_xor_next;
  logic [CW-1:0] raw_count, raw_count_next;
  logic [CW-1:0] destuffed_count, destuffed_count_next;

  logic [7:0]    exp_ctrl;
  logic          take;
  logic [7:0]    take_byte;
  logic [LW-1:0] len_w;

  assign exp_ctrl = seq_bit ? CTRL_SEQ1 : CTRL_SEQ0;
  assign len_w    = LW'(destuffed_count) - LW'(1);

  always_comb begin
    phase_next           = phase;
    seq_bit_next         = seq_bit;
    escape_pending_next  = escape_pending;
    bad_escape_next      = bad_escape;
    held_valid_next      = held_valid;
    held_byte_next       = held_byte;
    running_xor_next     = running_xor;
    raw_count_next       = raw_count;
    destuffed_count_next = destuffed_count;
    take                 = 1'b0;
    take_byte            = rx_byte;
    res                  = '0;
    res.kind             = KIND_PAYLOAD;
    case (phase)
      PH_FLAG: begin
        if (rx_byte == FLAG_BYTE) phase_next = PH_ADDR;
      end
      PH_ADDR: begin
        if (rx_byte == station_address) phase_next = PH_CTRL;
        else if (rx_byte != FLAG_BYTE) phase_next = PH_FLAG;
      end
      PH_CTRL: begin
        phase_next = (rx_byte == exp_ctrl) ? PH_HCHECK : PH_FLAG;
      end
      PH_HCHECK: begin
        if (rx_byte == (station_address ^ exp_ctrl)) begin
          phase_next           = PH_BODY;
          escape_pending_next  = 1'b0;
          bad_escape_next      = 1'b0;
          held_valid_next      = 1'b0;
          held_byte_next       = 8'h00;
          running_xor_next     = 8'h00;
          raw_count_next       = '0;
          destuffed_count_next = '0;
        end else begin
          phase_next = PH_FLAG;
        end
      end
      PH_BODY: begin
        if (rx_byte == FLAG_BYTE) begin
          phase_next = PH_FLAG;
          res.valid  = 1'b1;
          if (raw_count == '0) begin
            res.kind = KIND_EMPTY;
          end else if (bad_escape || escape_pending || running_xor != 8'h00) begin
            res.kind          = KIND_REJECT;
            res.reply_control = seq_bit ? REJ_SEQ1 : REJ_SEQ0;
          end else begin
            seq_bit_next      = ~seq_bit;
            res.kind          = KIND_ACCEPT;
            res.reply_control = seq_bit ? RR_SEQ0 : RR_SEQ1;
            res.frame_length  = (len_w > LW'(LENGTH_MAX)) ? LENGTH_MAX : len_w[8:0];
          end
        end else if (raw_count < CAP) begin
          raw_count_next = raw_count + CW'(1);
          if (!bad_escape) begin
            if (escape_pending) begin
              escape_pending_next = 1'b0;
              if (rx_byte == ESC_OF_FLAG) begin
                take      = 1'b1;
                take_byte = FLAG_BYTE;
              end else if (rx_byte == ESC_OF_ESC) begin
                take      = 1'b1;
                take_byte = ESC_BYTE;
              end else begin
                bad_escape_next = 1'b1;
              end
            end else if (rx_byte == ESC_BYTE) begin
              escape_pending_next = 1'b1;
            end else begin
              take = 1'b1;
            end
          end
        end
      end
      default: phase_next = PH_FLAG;
    endcase
    if (take) begin
      if (held_valid) begin
        res.valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = held_byte;
      end
      running_xor_next     = running_xor ^ take_byte;
      held_byte_next       = take_byte;
      held_valid_next      = 1'b1;
      destuffed_count_next = destuffed_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FLAG;
      seq_bit         <= 1'b0;
      escape_pending  <= 1'b0;
      bad_escape      <= 1'b0;
      held_valid      <= 1'b0;
      raw_count       <= '0;
      destuffed_count <= '0;
      running_xor     <= 8'h00;
    end else if (advance) begin
      phase           <= phase_next;
      seq_bit         <= seq_bit_next;
      escape_pending  <= escape_pending_next;
      bad_escape      <= bad_escape_next;
      held_valid      <= held_valid_next;
      raw_count       <= raw_count_next;
      destuffed_count <= destuffed_count_next;
      running_xor     <= running_xor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) held_byte <= held_byte_next;
  end

endmodule

FILE: hdl/stuffed_info_frame_receiver.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   rx_byte
// out       output     out_valid / out_ready kind, payload_byte, reply_control, frame_length
// cfg       input      cfg_write             cfg_data (station address)
//
// One byte per cycle while the output register is free: an input register feeds
// the frame state update, whose result is registered in the output register.
// The input stage holds only while a result waits in a full output register.
// Synchronous reset returns to flag hunt, sequence bit 0, address 0x03.
module stuffed_info_frame_receiver #(
  parameter int unsigned RawCapacity = sifr_pkg::RAW_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] payload_byte,
  output logic [7:0] reply_control,
  output logic [8:0] frame_length,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data
);
  import sifr_pkg::*;

  logic [7:0] station_address;
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       advance;
  res_t       step_res;
  res_t       out_res;
  logic       out_free;

  assign out_free = !out_res.valid || out_ready;
  assign advance  = stage_valid && (!step_res.valid || out_free);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= STATION_RST;
    end else if (cfg_write) begin
      station_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) stage_byte <= rx_byte;
  end

  sifr_step #(
    .RawCapacity(RawCapacity)
  ) u_step (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .rx_byte        (stage_byte),
    .station_address(station_address),
    .res            (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_res.valid <= 1'b0;
    end else if (out_free) begin
      out_res.valid <= advance && step_res.valid;
    end
    if (out_free && advance && step_res.valid) begin
      out_res.kind          <= step_res.kind;
      out_res.payload_byte  <= step_res.payload_byte;
      out_res.reply_control <= step_res.reply_control;
      out_res.frame_length  <= step_res.frame_length;
    end
  end

  assign out_valid     = out_res.valid;
  assign kind          = out_res.kind;
  assign payload_byte  = out_res.payload_byte;
  assign reply_control = out_res.reply_control;
  assign frame_length  = out_res.frame_length;

endmodule

FILE: bench/stuffed_info_frame_checker.sv
`timescale 1ns / 100ps
module stuffed_info_frame_checker
  import sifr_pkg::*;
#(
  parameter int unsigned RawCapacity = RAW_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] kind,
  input  logic [7:0] payload_byte,
  input  logic [7:0] reply_control,
  input  logic [8:0] frame_length,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         outstanding,
  output logic       seq_now,
  output int         line_bytes,
  output int         payload_count,
  output int         accept_count,
  output int         reject_count,
  output int         empty_count
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [7:0] reply_control;
    logic [8:0] frame_length;
  } frame_result_t;

  frame_result_t due_results[$];
  frame_result_t got;
  frame_result_t want;

  phase_t     hunt;
  logic       seq;
  logic       esc_open;
  logic       esc_bad;
  logic       held_vld;
  logic [7:0] held;
  logic [7:0] check_acc;
  logic [9:0] raw_seen;
  logic [9:0] kept;
  logic [7:0] station;

  task automatic clear_frame();
    esc_open  = 1'b0;
    esc_bad   = 1'b0;
    held_vld  = 1'b0;
    held      = 8'h00;
    check_acc = 8'h00;
    raw_seen  = '0;
    kept      = '0;
  endtask

  task automatic post_result(input kind_t k, input logic [7:0] pay, input logic [7:0] rep,
                             input logic [8:0] len);
    frame_result_t r;
    r.kind          = k;
    r.payload_byte  = pay;
    r.reply_control = rep;
    r.frame_length  = len;
    due_results.push_back(r);
    case (k)
      KIND_PAYLOAD: payload_count++;
      KIND_ACCEPT:  accept_count++;
      KIND_REJECT:  reject_count++;
      default:      empty_count++;
    endcase
  endtask

  task automatic take_byte(input logic [7:0] d);
    if (held_vld) post_result(KIND_PAYLOAD, held, NO_REPLY, 9'd0);
    check_acc = check_acc ^ d;
    held      = d;
    held_vld  = 1'b1;
    kept      = kept + 1'b1;
  endtask

  task automatic close_frame();
    logic [9:0] len;
    hunt = PH_FLAG;
    if (raw_seen == 0) begin
      post_result(KIND_EMPTY, 8'h00, NO_REPLY, 9'd0);
    end else if (esc_bad || esc_open || check_acc != 8'h00) begin
      post_result(KIND_REJECT, 8'h00, seq ? REJ_SEQ1 : REJ_SEQ0, 9'd0);
    end else begin
      len = kept - 1'b1;
      if (len > 10'(LENGTH_MAX)) len = 10'(LENGTH_MAX);
      seq = ~seq;
      post_result(KIND_ACCEPT, 8'h00, seq ? RR_SEQ1 : RR_SEQ0, len[8:0]);
    end
  endtask

  task automatic predict_line_byte(input logic [7:0] b);
    logic [7:0] ctl;
    ctl = seq ? CTRL_SEQ1 : CTRL_SEQ0;
    case (hunt)
      PH_FLAG: begin
        if (b == FLAG_BYTE) hunt = PH_ADDR;
      end
      PH_ADDR: begin
        if (b == station) hunt = PH_CTRL;
        else if (b != FLAG_BYTE) hunt = PH_FLAG;
      end
      PH_CTRL: begin
        hunt = (b == ctl) ? PH_HCHECK : PH_FLAG;
      end
      PH_HCHECK: begin
        if (b == (station ^ ctl)) begin
          hunt = PH_BODY;
          clear_frame();
        end else begin
          hunt = PH_FLAG;
        end
      end
      PH_BODY: begin
        if (b == FLAG_BYTE) begin
          close_frame();
        end else if (raw_seen < RawCapacity) begin
          raw_seen = raw_seen + 1'b1;
          if (!esc_bad) begin
            if (esc_open) begin
              esc_open = 1'b0;
              if (b == ESC_OF_FLAG) take_byte(FLAG_BYTE);
              else if (b == ESC_OF_ESC) take_byte(ESC_BYTE);
              else esc_bad = 1'b1;
            end else if (b == ESC_BYTE) begin
              esc_open = 1'b1;
            end else begin
              take_byte(b);
            end
          end
        end
      end
      default: hunt = PH_FLAG;
    endcase
  endtask

  task automatic note_mismatch(input bit have_want, input frame_result_t w,
                               input frame_result_t g);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_want)
        $display("%0t: mismatch: expected kind %0d byte %02h reply %02h length %0d,",
                 $time, w.kind, w.payload_byte, w.reply_control, w.frame_length,
                 " got kind %0d byte %02h reply %02h length %0d",
                 g.kind, g.payload_byte, g.reply_control, g.frame_length);
      else
        $display("%0t: result with nothing due: kind %0d byte %02h reply %02h length %0d",
                 $time, g.kind, g.payload_byte, g.reply_control, g.frame_length);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hunt     = PH_FLAG;
      seq      = 1'b0;
      station  = STATION_RST;
      clear_frame();
      due_results.delete();
      mismatches    = 0;
      line_bytes    = 0;
      payload_count = 0;
      accept_count  = 0;
      reject_count  = 0;
      empty_count   = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind          = kind_t'(kind);
        got.payload_byte  = payload_byte;
        got.reply_control = reply_control;
        got.frame_length  = frame_length;
        if (due_results.size() == 0) begin
          note_mismatch(1'b0, got, got);
        end else begin
          want = due_results.pop_front();
          if (got.kind != want.kind || got.payload_byte != want.payload_byte ||
              got.reply_control != want.reply_control ||
              got.frame_length != want.frame_length)
            note_mismatch(1'b1, want, got);
        end
      end
      if (cfg_write) station = cfg_data;
      if (in_valid && in_ready) begin
        line_bytes++;
        predict_line_byte(rx_byte);
      end
    end
    outstanding <= due_results.size();
    seq_now     <= seq;
  end

endmodule

FILE: bench/stuffed_info_frame_receiver_test.sv
`timescale 1ns / 100ps
module stuffed_info_frame_receiver_test;
  import sifr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 150;
  localparam int PHASES         = 5;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_CHECK,
    FRAME_BAD_ESCAPE,
    FRAME_TAIL_ESCAPE,
    FRAME_BAD_HEADER,
    FRAME_EMPTY,
    FRAME_OPEN
  } frame_flaw_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [7:0] reply_control;
  logic [8:0] frame_length;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  int   mismatches;
  int   outstanding;
  logic seq_now;
  int   line_bytes;
  int   payload_count;
  int   accept_count;
  int   reject_count;
  int   empty_count;

  logic [7:0] station = STATION_RST;
  logic [7:0] frame_body[$];
  int         bytes_sent = 0;
  int         settings_used = 1;
  int         tx_calm_left = 0;
  bit         tx_calm = 1'b0;
  int         idle_cycles = 0;

  stuffed_info_frame_receiver u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .reply_control(reply_control),
    .frame_length (frame_length),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  stuffed_info_frame_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .reply_control(reply_control),
    .frame_length (frame_length),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .seq_now      (seq_now),
    .line_bytes   (line_bytes),
    .payload_count(payload_count),
    .accept_count (accept_count),
    .reject_count (reject_count),
    .empty_count  (empty_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("** stuffed_info_frame_receiver: FAILED **");
      $finish;
    end
  end

  initial begin : result_side
    int gap;
    int calm_left;
    bit calm;
    calm_left = 0;
    calm      = 1'b0;
    forever begin
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(8, 40);
      end
      calm_left--;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_calm_left == 0) begin
      tx_calm      = ($urandom_range(0, 3) == 0);
      tx_calm_left = $urandom_range(8, 40);
    end
    tx_calm_left--;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // hold the sender until every expected result is back, then let the pipe settle
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_station(input logic [7:0] a);
    hold_until_drained();
    cfg_write <= 1'b1;
    cfg_data  <= a;
    @(posedge clk);
    cfg_write <= 1'b0;
    station = a;
    settings_used++;
  endtask

  // frame_body holds the destuffed payload; the trailer check is appended here
  task automatic send_frame(input frame_flaw_t flaw, input int spill);
    logic [7:0] raw[$];
    logic [7:0] addr;
    logic [7:0] ctl;
    logic [7:0] hcheck;
    logic [7:0] sum;
    logic [7:0] junk;
    int         spot;
    send_byte(FLAG_BYTE);
    addr   = station;
    ctl    = seq_now ? CTRL_SEQ1 : CTRL_SEQ0;
    hcheck = addr ^ ctl;
    if (flaw == FRAME_BAD_HEADER) begin
      junk = 8'($urandom_range(1, 255));
      case ($urandom_range(0, 2))
        0:       addr = addr ^ junk;
        1:       ctl = ctl ^ junk;
        default: hcheck = hcheck ^ junk;
      endcase
    end
    send_byte(addr);
    send_byte(ctl);
    send_byte(hcheck);
    if (flaw != FRAME_EMPTY) begin
      sum = 8'h00;
      foreach (frame_body[i]) sum = sum ^ frame_body[i];
      if (flaw == FRAME_BAD_CHECK) sum = sum ^ 8'($urandom_range(1, 255));
      frame_body.push_back(sum);
      spot = $urandom_range(0, frame_body.size() - 1);
      do junk = 8'($urandom_range(0, 255));
      while (junk == FLAG_BYTE || junk == ESC_OF_FLAG || junk == ESC_OF_ESC);
      foreach (frame_body[i]) begin
        if (flaw == FRAME_BAD_ESCAPE && i == spot) begin
          raw.push_back(ESC_BYTE);
          raw.push_back(junk);
        end
        if (frame_body[i] == FLAG_BYTE || frame_body[i] == ESC_BYTE) begin
          raw.push_back(ESC_BYTE);
          raw.push_back(frame_body[i] == FLAG_BYTE ? ESC_OF_FLAG : ESC_OF_ESC);
        end else begin
          raw.push_back(frame_body[i]);
        end
      end
      if (flaw == FRAME_TAIL_ESCAPE) raw.push_back(ESC_BYTE);
      repeat (spill) begin
        do junk = 8'($urandom_range(0, 255)); while (junk == FLAG_BYTE);
        raw.push_back(junk);
      end
      foreach (raw[i]) send_byte(raw[i]);
    end
    frame_body.delete();
    if (flaw != FRAME_OPEN) send_byte(FLAG_BYTE);
  endtask

  task automatic send_random_frame();
    int          pick;
    int          len;
    logic [7:0]  d;
    frame_flaw_t flaw;
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    repeat (len) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0:       d = FLAG_BYTE;
          1:       d = ESC_BYTE;
          2:       d = ESC_OF_FLAG;
          default: d = ESC_OF_ESC;
        endcase
      end else begin
        d = 8'($urandom_range(0, 255));
      end
      frame_body.push_back(d);
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) flaw = FRAME_GOOD;
    else if (pick < 67) flaw = FRAME_BAD_CHECK;
    else if (pick < 77) flaw = FRAME_BAD_ESCAPE;
    else if (pick < 83) flaw = FRAME_TAIL_ESCAPE;
    else if (pick < 90) flaw = FRAME_BAD_HEADER;
    else if (pick < 95) flaw = FRAME_EMPTY;
    else flaw = FRAME_OPEN;
    send_frame(flaw, 0);
  endtask

  initial begin : stimulus
    logic [7:0] ctl;
    logic [7:0] sum;
    logic [7:0] plan[PHASES];
    int         quota;
    plan[0] = 8'h00;
    plan[1] = 8'hFF;
    plan[2] = FLAG_BYTE;
    plan[3] = 8'($urandom_range(0, 255));
    plan[4] = STATION_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // repeated flag before the address, then an empty body
    send_byte(FLAG_BYTE);
    send_frame(FRAME_EMPTY, 0);
    // both escape pairs in the body
    frame_body.push_back(FLAG_BYTE);
    frame_body.push_back(ESC_BYTE);
    send_frame(FRAME_GOOD, 0);
    send_frame(FRAME_TAIL_ESCAPE, 0);
    // change the address between address and control bytes
    send_byte(FLAG_BYTE);
    send_byte(station);
    set_station(8'h55);
    ctl = seq_now ? CTRL_SEQ1 : CTRL_SEQ0;
    send_byte(ctl);
    send_byte(station ^ ctl);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(FLAG_BYTE);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_station(plan[ph]);
      if (ph == 1) begin
        // close any open frame, then overflow the body store
        send_byte(FLAG_BYTE);
        sum = 8'h00;
        repeat (511) begin
          frame_body.push_back(8'($urandom_range(0, 8'h7B)));
          sum = sum ^ frame_body[$];
        end
        if (sum == FLAG_BYTE || sum == ESC_BYTE) frame_body[0] = frame_body[0] ^ 8'h01;
        send_frame(FRAME_GOOD, 6);
      end
      quota = bytes_sent + RANDOM_BYTES / PHASES;
      while (bytes_sent < quota) send_random_frame();
    end

    hold_until_drained();
    repeat (6) @(posedge clk);
    $display("run covered %0d line bytes over %0d station settings", line_bytes, settings_used);
    $display("results: %0d payload bytes, %0d accepted, %0d rejected, %0d empty frames",
             payload_count, accept_count, reject_count, empty_count);
    if (mismatches == 0 && outstanding == 0)
      $display("** stuffed_info_frame_receiver: PASSED **");
    else
      $display("** stuffed_info_frame_receiver: FAILED **");
    $finish;
  end

endmodule
